FILE: rtl/pbra_pkg.sv
// Package: shared types and fixed widths of the page bitmap run allocator.
`timescale 1ns / 1ps
package pbra_pkg;

    localparam int CFG_W  = 13;   // usable page count register
    localparam int PTW    = 14;   // scan pointer, holds any count up to 8191 plus a word step
    localparam int WORD_W = 32;   // bitmap word

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_PAGES = 2'd1,
        ST_BAD_FREE = 2'd2,
        ST_ZERO_REQ = 2'd3
    } t_status;

    // One result word plus the bitmap update that goes with it.
    typedef struct packed {
        t_status        status;
        logic [PTW-1:0] page;
        logic           first;
        logic           contig;
        logic           last;
        logic           wr_en;
        logic           wr_val;
    } t_rec;

endpackage

FILE: rtl/pbra_if.sv
// Interfaces: request channel and result channel.
`timescale 1ns / 1ps
interface pbra_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic        pool;
    logic [4:0]  request_pages;
    logic [11:0] page_index;
    modport source(output valid, operation, pool, request_pages, page_index, input ready);
    modport sink(input valid, operation, pool, request_pages, page_index, output ready);
endinterface

interface pbra_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [11:0] granted_page;
    logic        first_of_run;
    logic        contiguous;
    logic        last;
    modport source(output valid, status, granted_page, first_of_run, contiguous, last,
                   input ready);
    modport sink(input valid, status, granted_page, first_of_run, contiguous, last,
                 output ready);
endinterface

FILE: rtl/pbra_map.sv
// Page bitmap memory: word read port, single-bit write port, clearing sweep.
`timescale 1ns / 1ps
module pbra_map #(
    parameter int PAGES = 4096
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic [$clog2((PAGES+31)/32)-1:0]        i_rd_addr,
    output logic [pbra_pkg::WORD_W-1:0]             o_rd_data,
    input  logic                                    i_we,
    input  logic [$clog2((PAGES+31)/32)-1:0]        i_wr_addr,
    input  logic [4:0]                              i_wr_bit,
    input  logic                                    i_wr_val,
    output logic                                    o_busy
);
    import pbra_pkg::*;

    localparam int WORDS = (PAGES + 31) / 32;
    localparam int WAW   = $clog2(WORDS);

    logic [WORD_W-1:0] r_mem [WORDS];
    logic [WORD_W-1:0] r_rd_data;
    logic [WAW-1:0]    r_clr_addr;
    logic              r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == WAW'(WORDS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_we) begin
            r_mem[i_wr_addr][i_wr_bit] <= i_wr_val;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

FILE: rtl/pbra_fifo.sv
// Short record queue between the scan front end and the result back end.
`timescale 1ns / 1ps
module pbra_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_push_ready,
    input  pbra_pkg::t_rec i_push_rec,
    output logic           o_pop_valid,
    input  logic           i_pop,
    output pbra_pkg::t_rec o_pop_rec,
    output logic           o_empty
);
    import pbra_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    t_rec          r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_push_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_empty      = (r_cnt == '0);
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;
    assign o_pop_rec    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_mem[r_wp] <= i_push_rec;
                r_wp        <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: rtl/pbra_front.sv
// Front end: accepts requests, scans the bitmap from the pool hint, queues results.
`timescale 1ns / 1ps
module pbra_front #(
    parameter int PAGES   = 4096,
    parameter int MAX_RUN = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic [pbra_pkg::CFG_W-1:0]          i_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_operation,
    input  logic                                i_pool,
    input  logic [4:0]                          i_request_pages,
    input  logic [11:0]                         i_page_index,
    input  logic                                i_q_empty,
    output logic                                o_push,
    input  logic                                i_push_ready,
    output pbra_pkg::t_rec                      o_rec,
    output logic [$clog2((PAGES+31)/32)-1:0]    o_rd_addr,
    input  logic [pbra_pkg::WORD_W-1:0]         i_rd_data
);
    import pbra_pkg::*;

    localparam int WAW = $clog2((PAGES + 31) / 32);
    localparam int RW  = $clog2(MAX_RUN + 1);
    localparam int TW  = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_FETCH, S_SCAN, S_FCHK, S_PUSH, S_EMIT
    } t_state;

    t_state         r_state;
    logic [PTW-1:0] r_khint;
    logic [PTW-1:0] r_uhint;
    logic [PTW-1:0] r_pg;
    logic [PTW-1:0] r_start;
    logic           r_wrapped;
    logic           r_op;
    logic           r_pool;
    logic [RW-1:0]  r_req;
    logic [RW-1:0]  r_found;
    logic [RW-1:0]  r_k;
    logic           r_contig;
    logic [PTW-1:0] r_taken [MAX_RUN];
    t_rec           r_rec;

    // scan step on the current word
    logic [PTW-1:0]    n_ext;
    logic [PTW-1:0]    base;
    logic [4:0]        off;
    logic [PTW-1:0]    limit;
    logic [PTW-1:0]    rem;
    logic              at_end;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] free_bits;
    logic [4:0]        b;
    logic [PTW-1:0]    page_new;
    logic [PTW-1:0]    page_nxt;
    logic [RW-1:0]     found_inc;
    logic [PTW-1:0]    hint_sel;
    logic [RW-1:0]     req_sat;
    t_rec              emit_rec;

    // lone final word: status, page and the bitmap clear that goes with it
    function automatic t_rec single_rec(t_status st, logic [PTW-1:0] pg, logic clr);
        t_rec rec;
        rec        = '0;
        rec.status = st;
        rec.page   = pg;
        rec.last   = 1'b1;
        rec.wr_en  = clr;
        rec.wr_val = 1'b0;
        return rec;
    endfunction

    assign n_ext  = PTW'(i_n);
    assign base   = {r_pg[PTW-1:5], 5'b0};
    assign off    = r_pg[4:0];
    assign limit  = r_wrapped ? r_start : n_ext;
    assign at_end = (r_pg >= limit);
    assign rem    = limit - base;

    always_comb begin
        mask = (rem >= PTW'(WORD_W)) ? '1 : ((WORD_W'(1) << rem[4:0]) - 1'b1);
        mask = mask & ('1 << off);
        free_bits = ~i_rd_data & mask;
        b = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                b = 5'(i);
            end
        end
    end

    assign page_new  = base + PTW'(b);
    assign page_nxt  = page_new + 1'b1;
    assign found_inc = r_found + 1'b1;
    assign hint_sel  = i_pool ? r_uhint : r_khint;
    assign req_sat   = (int'(i_request_pages) > MAX_RUN) ? RW'(MAX_RUN) : RW'(i_request_pages);

    always_comb begin
        emit_rec        = '0;
        emit_rec.status = ST_OK;
        emit_rec.page   = r_taken[r_k[TW-1:0]];
        emit_rec.first  = (r_k == '0);
        emit_rec.contig = r_contig;
        emit_rec.last   = (r_k == RW'(r_req - 1'b1));
        emit_rec.wr_en  = 1'b1;
        emit_rec.wr_val = 1'b1;
    end

    assign o_ready   = (r_state == S_IDLE) && i_q_empty && i_en;
    assign o_push    = (r_state == S_PUSH) || (r_state == S_EMIT);
    assign o_rec     = (r_state == S_EMIT) ? emit_rec : r_rec;
    assign o_rd_addr = WAW'(r_pg >> 5);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_khint <= '0;
            r_uhint <= PTW'(512);
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_op   <= i_operation;
                        r_pool <= i_pool;
                        if (i_operation) begin
                            r_rec <= single_rec(ST_BAD_FREE, PTW'(i_page_index), 1'b0);
                            if (PTW'(i_page_index) >= n_ext) begin
                                r_state <= S_PUSH;
                            end else begin
                                r_pg    <= PTW'(i_page_index);
                                r_state <= S_FETCH;
                            end
                        end else if (i_request_pages == '0) begin
                            r_rec   <= single_rec(ST_ZERO_REQ, '0, 1'b0);
                            r_state <= S_PUSH;
                        end else begin
                            r_pg      <= (hint_sel >= n_ext) ? '0 : hint_sel;
                            r_start   <= (hint_sel >= n_ext) ? '0 : hint_sel;
                            r_wrapped <= 1'b0;
                            r_found   <= '0;
                            r_contig  <= 1'b1;
                            r_req     <= req_sat;
                            r_state   <= S_FETCH;
                        end
                    end
                end
                S_FETCH: begin
                    r_state <= r_op ? S_FCHK : S_SCAN;
                end
                S_FCHK: begin
                    if (i_rd_data[r_pg[4:0]]) begin
                        r_rec <= single_rec(ST_OK, r_rec.page, 1'b1);
                    end else begin
                        r_rec <= single_rec(ST_BAD_FREE, r_rec.page, 1'b0);
                    end
                    r_state <= S_PUSH;
                end
                S_SCAN: begin
                    if (at_end) begin
                        if (!r_wrapped) begin
                            r_pg      <= '0;
                            r_wrapped <= 1'b1;
                            if (r_found != '0) begin
                                r_contig <= 1'b0;
                            end
                            r_state <= S_FETCH;
                        end else begin
                            // not enough pages: hint goes to the first free page seen
                            r_rec <= single_rec(ST_NO_PAGES, '0, 1'b0);
                            if (r_found != '0) begin
                                if (r_pool) r_uhint <= r_taken[0];
                                else        r_khint <= r_taken[0];
                            end
                            r_state <= S_PUSH;
                        end
                    end else if (free_bits != '0) begin
                        if (r_found == '0) begin
                            r_contig <= 1'b1;
                        end else if (b != off) begin
                            r_contig <= 1'b0;
                        end
                        r_taken[r_found[TW-1:0]] <= page_new;
                        r_found <= found_inc;
                        if (found_inc == r_req) begin
                            if (r_pool) r_uhint <= (page_nxt >= n_ext) ? '0 : page_nxt;
                            else        r_khint <= (page_nxt >= n_ext) ? '0 : page_nxt;
                            r_k     <= '0;
                            r_state <= S_EMIT;
                        end else begin
                            r_pg    <= page_nxt;
                            r_state <= (b == 5'd31) ? S_FETCH : S_SCAN;
                        end
                    end else begin
                        // rest of the word is in use
                        if (r_found != '0) begin
                            r_contig <= 1'b0;
                        end
                        r_pg    <= base + PTW'(WORD_W);
                        r_state <= S_FETCH;
                    end
                end
                S_PUSH: begin
                    if (i_push_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (i_push_ready) begin
                        r_k <= r_k + 1'b1;
                        if (emit_rec.last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/pbra_back.sv
// Back end: pops queued records, updates the bitmap, holds the result register.
`timescale 1ns / 1ps
module pbra_back #(
    parameter int PAGES = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    output logic                                o_q_pop,
    input  pbra_pkg::t_rec                      i_q_rec,
    output logic                                o_we,
    output logic [$clog2((PAGES+31)/32)-1:0]    o_wr_addr,
    output logic [4:0]                          o_wr_bit,
    output logic                                o_wr_val,
    output logic                                o_valid,
    input  logic                                i_ready,
    output pbra_pkg::t_rec                      o_rec
);
    import pbra_pkg::*;

    localparam int WAW = $clog2((PAGES + 31) / 32);

    logic r_valid;
    t_rec r_rec;
    logic take;

    assign take      = i_q_valid && (!r_valid || i_ready);
    assign o_q_pop   = take;
    assign o_we      = take && i_q_rec.wr_en;
    assign o_wr_addr = WAW'(i_q_rec.page >> 5);
    assign o_wr_bit  = i_q_rec.page[4:0];
    assign o_wr_val  = i_q_rec.wr_val;
    assign o_valid   = r_valid;
    assign o_rec     = r_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
            r_rec   <= i_q_rec;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

FILE: rtl/page_bitmap_run_allocator.sv
// Top level: page bitmap run allocator with next-fit kernel and user hints.
//
//  channel   dir  handshake        payload
//  i_in      in   valid/ready      operation, pool, request_pages, page_index
//  o_out     out  valid/ready      status, granted_page, first_of_run, contiguous, last
//  i_cfg_*   in   i_cfg_we strobe  i_cfg_data = usable_pages (13 bits)
//
// A free reads the page's bitmap word and checks its bit. An allocation fetches each bitmap
// word visited through the single read port of the bitmap, records the free pages found,
// then emits one result word per page granted.
// After reset the bitmap is cleared one word per cycle while i_in.ready stays low.
// A new word is taken once the previous one has drained into the result register;
// a stalled o_out backs up the queue.
`timescale 1ns / 1ps
module page_bitmap_run_allocator #(
    parameter int PAGES   = 4096,
    parameter int MAX_RUN = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    pbra_in_if.sink                     i_in,
    pbra_out_if.source                  o_out,
    input  logic                        i_cfg_we,
    input  logic [pbra_pkg::CFG_W-1:0]  i_cfg_data
);
    import pbra_pkg::*;

    localparam int WAW = $clog2((PAGES + 31) / 32);

    logic [CFG_W-1:0]  r_usable;
    logic [CFG_W-1:0]  n_pages;      // effective page count
    logic              map_busy;
    logic [WAW-1:0]    rd_addr;
    logic [WORD_W-1:0] rd_data;
    logic              we;
    logic [WAW-1:0]    wr_addr;
    logic [4:0]        wr_bit;
    logic              wr_val;
    logic              push;
    logic              push_ready;
    t_rec              push_rec;
    logic              q_valid;
    logic              q_pop;
    t_rec              q_rec;
    logic              q_empty;
    t_rec              out_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_usable <= CFG_W'(4096);
        end else if (i_cfg_we) begin
            r_usable <= i_cfg_data;
        end
    end

    assign n_pages = (int'(r_usable) > PAGES) ? CFG_W'(PAGES) : r_usable;

    pbra_map #(.PAGES(PAGES)) u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_we      (we),
        .i_wr_addr (wr_addr),
        .i_wr_bit  (wr_bit),
        .i_wr_val  (wr_val),
        .o_busy    (map_busy)
    );

    // front end scans; it only starts on an empty queue so the bitmap is current
    pbra_front #(.PAGES(PAGES), .MAX_RUN(MAX_RUN)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (!map_busy),
        .i_n             (n_pages),
        .i_valid         (i_in.valid),
        .o_ready         (i_in.ready),
        .i_operation     (i_in.operation),
        .i_pool          (i_in.pool),
        .i_request_pages (i_in.request_pages),
        .i_page_index    (i_in.page_index),
        .i_q_empty       (q_empty),
        .o_push          (push),
        .i_push_ready    (push_ready),
        .o_rec           (push_rec),
        .o_rd_addr       (rd_addr),
        .i_rd_data       (rd_data)
    );

    pbra_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_push_rec   (push_rec),
        .o_pop_valid  (q_valid),
        .i_pop        (q_pop),
        .o_pop_rec    (q_rec),
        .o_empty      (q_empty)
    );

    // back end marks or clears the page as each word with a bitmap update leaves the queue
    pbra_back #(.PAGES(PAGES)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .i_q_rec   (q_rec),
        .o_we      (we),
        .o_wr_addr (wr_addr),
        .o_wr_bit  (wr_bit),
        .o_wr_val  (wr_val),
        .o_valid   (o_out.valid),
        .i_ready   (o_out.ready),
        .o_rec     (out_rec)
    );

    assign o_out.status       = out_rec.status;
    assign o_out.granted_page = out_rec.page[11:0];
    assign o_out.first_of_run = out_rec.first;
    assign o_out.contiguous   = out_rec.contig;
    assign o_out.last         = out_rec.last;

endmodule

FILE: rtl/pbra_checker.sv
// Port-level checker for the allocator, bound to the top level.
`timescale 1ns / 1ps
module pbra_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_status,
    input logic [11:0] i_page,
    input logic        i_first,
    input logic        i_contig,
    input logic        i_last
);
    import pbra_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_page))
        else $error("result dropped or changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_fail_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_OK) |-> i_last && !i_first && !i_contig)
        else $error("error result not a lone final word");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_first && !i_last |=> !i_out_valid || !i_first)
        else $error("new run started before previous run ended");

endmodule

bind page_bitmap_run_allocator pbra_checker u_pbra_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_page      (o_out.granted_page),
    .i_first     (o_out.first_of_run),
    .i_contig    (o_out.contiguous),
    .i_last      (o_out.last)
);

FILE: tb/page_bitmap_run_allocator_checker.sv
// Checker: predicts the allocator's result words and compares them with o_out.
`timescale 1ns / 1ps
module page_bitmap_run_allocator_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_data,
    pbra_in_if          i_in,
    pbra_out_if         i_out,
    output int          o_fail_count,
    output int          o_pending
);
    import pbra_pkg::*;

    localparam int NPAGES  = 4096;
    localparam int RUN_MAX = 16;

    typedef struct packed {
        t_status     status;
        logic [11:0] page;
        logic        first;
        logic        contig;
        logic        last;
    } t_word;

    logic        used_map [NPAGES];
    logic [11:0] kern_hint, user_hint;
    logic [12:0] usable;
    t_word       expected_words [$];

    assign o_pending = expected_words.size();

    function automatic int eff_pages();
        return (usable > NPAGES) ? NPAGES : int'(usable);
    endfunction

    task automatic push_word(t_status st, logic [11:0] pg, logic f, logic c, logic l);
        t_word w;
        w = '{status: st, page: pg, first: f, contig: c, last: l};
        expected_words.push_back(w);
    endtask

    task automatic predict(logic op, logic pool, logic [4:0] req_in, logic [11:0] idx);
        int n, req, found, pg, i;
        int taken [RUN_MAX];
        logic contig;
        n = eff_pages();
        if (op) begin
            if (idx >= n || !used_map[idx]) begin
                push_word(ST_BAD_FREE, idx, 1'b0, 1'b0, 1'b1);
            end else begin
                used_map[idx] = 1'b0;
                push_word(ST_OK, idx, 1'b0, 1'b0, 1'b1);
            end
            return;
        end
        if (req_in == 0) begin
            push_word(ST_ZERO_REQ, 12'd0, 1'b0, 1'b0, 1'b1);
            return;
        end
        req = (req_in > RUN_MAX) ? RUN_MAX : int'(req_in);
        pg = pool ? user_hint : kern_hint;
        if (pg >= n) pg = 0;
        found = 0;
        contig = 1'b1;
        for (i = 0; i < n; i++) begin
            if (!used_map[pg]) begin
                taken[found % RUN_MAX] = pg;
                found++;
                if (found == 1) contig = 1'b1;
                if (found >= req) break;
            end else begin
                contig = 1'b0;
            end
            pg++;
            if (pg >= n) begin
                pg = 0;
                contig = 1'b0;
            end
        end
        if (found < req) begin
            // short: hint parks on the first free page seen, nothing marked
            if (found > 0) begin
                if (pool) user_hint = 12'(taken[0]);
                else kern_hint = 12'(taken[0]);
            end
            push_word(ST_NO_PAGES, 12'd0, 1'b0, 1'b0, 1'b1);
            return;
        end
        for (i = 0; i < req; i++) begin
            used_map[taken[i]] = 1'b1;
            push_word(ST_OK, 12'(taken[i]), i == 0, contig, i == req - 1);
        end
        pg = taken[req-1] + 1;
        if (pg >= n) pg = 0;
        if (pool) user_hint = 12'(pg);
        else kern_hint = 12'(pg);
    endtask

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_word w;
        if (!i_rst_n) begin
            foreach (used_map[k]) used_map[k] = 1'b0;
            usable = 13'd4096;
            kern_hint = 12'd0;
            user_hint = 12'd512;
            expected_words.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) usable = i_cfg_data;
            if (i_in.valid && i_in.ready)
                predict(i_in.operation, i_in.pool, i_in.request_pages, i_in.page_index);
            if (i_out.valid && i_out.ready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected result word: page %0d", i_out.granted_page);
                    o_fail_count++;
                end else begin
                    w = expected_words.pop_front();
                    check_field("status", w.status, i_out.status);
                    check_field("granted_page", w.page, i_out.granted_page);
                    check_field("first_of_run", w.first, i_out.first_of_run);
                    check_field("contiguous", w.contig, i_out.contiguous);
                    check_field("last", w.last, i_out.last);
                end
            end
        end
    end
endmodule

FILE: tb/page_bitmap_run_allocator_tb.sv
// Testbench top: drives requests and config, randomizes stalls, gives the verdict.
`timescale 1ns / 1ps
module page_bitmap_run_allocator_tb;
    import pbra_pkg::*;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;
    localparam logic POOL_KERN = 1'b0;
    localparam logic POOL_USER = 1'b1;
    localparam int   CYCLE_LIMIT = 1500000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [12:0] cfg_data = 13'd0;
    logic        quiet = 1'b0;   // no idling in the final stretch
    int          fail_count, pending;
    int          cycles = 0;
    int          cur_n = 4096;

    pbra_in_if  in_ch();
    pbra_out_if out_ch();

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    page_bitmap_run_allocator dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data)
    );

    page_bitmap_run_allocator_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_in(in_ch), .i_out(out_ch), .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL page_bitmap_run_allocator");
            $finish;
        end
    end

    // Receiver: ready toggles in random bursts unless in the quiet stretch.
    initial begin
        int burst;
        out_ch.ready = 1'b0;
        forever begin
            burst = $urandom_range(1, 10);
            out_ch.ready = quiet || ($urandom_range(0, 2) != 0);
            repeat (burst) @(negedge clk);
        end
    end

    // ready only moves at the rising edge, so its value at the falling edge
    // tells whether the next rising edge accepts the word
    task automatic send_word(logic op, logic pool, logic [4:0] req, logic [11:0] idx);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.operation = op;
        in_ch.pool = pool;
        in_ch.request_pages = req;
        in_ch.page_index = idx;
        while (!in_ch.ready) @(negedge clk);
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic drain();
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        // a failed scan has already finished when its single word comes out
        repeat (2 * (4096 / 32) + 64) @(negedge clk);
    endtask

    task automatic set_pages(logic [12:0] v);
        drain();
        cfg_data = v;
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        cur_n = (v > 4096) ? 4096 : int'(v);
    endtask

    // Mostly allocations and frees of recently plausible pages, some noise.
    task automatic random_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            send_word(OP_ALLOC, 1'($urandom_range(0, 1)), 5'($urandom_range(1, 16)),
                      12'($urandom_range(0, 4095)));
        else if (pick < 58)
            send_word(OP_ALLOC, 1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                      12'($urandom_range(0, 4095)));
        else if (pick < 92)
            send_word(OP_FREE, 1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                      12'((cur_n > 1) ? $urandom_range(0, cur_n - 1) : 0));
        else
            send_word(OP_FREE, 1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                      12'($urandom_range(0, 4095)));
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.operation = OP_ALLOC;
        in_ch.pool = POOL_KERN;
        in_ch.request_pages = 5'd0;
        in_ch.page_index = 12'd0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed: zero request, oversize saturation, both pools, free cases.
        send_word(OP_ALLOC, POOL_KERN, 5'd0, 12'hFFF);
        send_word(OP_ALLOC, POOL_KERN, 5'd31, 12'd0);
        send_word(OP_ALLOC, POOL_USER, 5'd16, 12'd0);
        send_word(OP_ALLOC, POOL_USER, 5'd1, 12'd0);
        send_word(OP_FREE, POOL_USER, 5'd31, 12'd3);
        send_word(OP_FREE, POOL_KERN, 5'd0, 12'd3);      // already free
        send_word(OP_FREE, POOL_KERN, 5'd0, 12'hFFF);    // never used
        send_word(OP_ALLOC, POOL_KERN, 5'd4, 12'd0);     // next fit from the kernel hint, hole left: contiguous
        send_word(OP_FREE, POOL_KERN, 5'd0, 12'd512);

        // Tiny map: wraps, out-of-range frees, hint beyond count, exhaustion.
        set_pages(13'd2);
        send_word(OP_FREE, POOL_KERN, 5'd0, 12'd2);
        send_word(OP_ALLOC, POOL_USER, 5'd1, 12'd0);     // user hint past count
        send_word(OP_ALLOC, POOL_KERN, 5'd3, 12'd0);     // not enough
        send_word(OP_FREE, POOL_KERN, 5'd0, 12'd1);
        send_word(OP_FREE, POOL_KERN, 5'd0, 12'd0);
        send_word(OP_ALLOC, POOL_KERN, 5'd2, 12'd0);
        send_word(OP_ALLOC, POOL_USER, 5'd1, 12'd0);     // full map

        // Register above the page count clamps to 4096.
        set_pages(13'h1FFF);
        send_word(OP_FREE, POOL_KERN, 5'd0, 12'd0);
        send_word(OP_FREE, POOL_KERN, 5'd0, 12'd1);
        send_word(OP_ALLOC, POOL_KERN, 5'd16, 12'd0);

        // Random phases at several map sizes; small maps give wraps and shortages.
        set_pages(13'd40);
        repeat (120) random_word();
        drain();   // sender holds off until every result is back
        set_pages(13'd4096);
        repeat (100) random_word();
        set_pages(13'd7);
        repeat (60) random_word();
        set_pages(13'd100);
        repeat (60) random_word();
        quiet = 1'b1;
        repeat (80) random_word();

        drain();
        if (fail_count == 0) begin
            $display("PASS page_bitmap_run_allocator");
        end else begin
            $display("FAIL page_bitmap_run_allocator");
        end
        $finish;
    end
endmodule
